// File: src/cpr_pkg.sv
// Shared types and constants for the camera primary ray direction pipeline.
`default_nettype none
package cpr_pkg;

   localparam int DIR_W  = 16;
   localparam int MAG_W  = 30;
   localparam int SUM_W  = 62;
   localparam int ROOT_W = 31;
   localparam int NUM_W  = 46;
   localparam int QUO_W  = 15;

   localparam logic [24:0]      ONE_Q24 = 25'h100_0000;
   localparam logic [QUO_W-1:0] UNIT_Q14 = 15'h4000;

   localparam logic [23:0] INV_WIDTH_RST    = 24'h00_8000;
   localparam logic [23:0] INV_HEIGHT_RST   = 24'h00_8000;
   localparam logic [23:0] ASPECT_RST       = 24'h01_0000;
   localparam logic [23:0] TAN_HALF_FOV_RST = 24'h01_0000;
   localparam logic [47:0] RIGHT_RST        = 48'h0000_0000_4000;
   localparam logic [47:0] UP_RST           = 48'h0000_4000_0000;
   localparam logic [47:0] FORWARD_RST      = 48'h4000_0000_0000;

   typedef enum logic [2:0] {
      REG_INV_WIDTH,
      REG_INV_HEIGHT,
      REG_ASPECT_RATIO,
      REG_TAN_HALF_FOV,
      REG_BASIS_RIGHT,
      REG_BASIS_UP,
      REG_BASIS_FORWARD
   } csr_index_type;

   typedef struct packed {
      logic [2:0]             neg;
      logic [2:0][MAG_W-1:0]  mag;
   } lane_type;

   typedef struct packed {
      logic [2:0]             neg;
      logic                   zero;
      logic [ROOT_W-1:0]      root;
      logic [2:0][NUM_W-1:0]  rem;
      logic [2:0][QUO_W-1:0]  quo;
   } div_type;

endpackage
`default_nettype wire

// File: src/camera_primary_ray_direction.sv
// Pinhole camera primary ray direction pipeline with APB register file.
// Pipeline: 11 arithmetic stages, 31 square-root stages, 1 divide setup stage,
// 15 divide stages, 1 output register.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, active high; clears all valid bits and loads register defaults.
`default_nettype none
module camera_primary_ray_direction #(
   parameter int PIXEL_BITS = 12,
   localparam int REQ_W = ((2 * PIXEL_BITS + 7) / 8) * 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_W-1:0]  req_tdata,   // pixel_x, pixel_y, zero pad
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [47:0]            rsp_tdata,   // dir_x, dir_y, dir_z
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [5:0]        csr_paddr,
   input  wire logic [63:0]       csr_pwdata,
   output logic [63:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int PW   = PIXEL_BITS + 25;
   localparam int UW   = (PW + 1 > 33) ? PW + 1 : 33;
   localparam int NSTG = 11 + cpr_pkg::ROOT_W + 1 + cpr_pkg::QUO_W + 1;

   logic [23:0] inv_width_ff, inv_height_ff, aspect_ratio_ff, tan_half_fov_ff;
   logic [47:0] basis_right_ff, basis_up_ff, basis_forward_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_width_ff     <= cpr_pkg::INV_WIDTH_RST;
         inv_height_ff    <= cpr_pkg::INV_HEIGHT_RST;
         aspect_ratio_ff  <= cpr_pkg::ASPECT_RST;
         tan_half_fov_ff  <= cpr_pkg::TAN_HALF_FOV_RST;
         basis_right_ff   <= cpr_pkg::RIGHT_RST;
         basis_up_ff      <= cpr_pkg::UP_RST;
         basis_forward_ff <= cpr_pkg::FORWARD_RST;
      end else if (csr_wr) begin
         case (cpr_pkg::csr_index_type'(csr_paddr[5:3]))
            cpr_pkg::REG_INV_WIDTH:     inv_width_ff     <= csr_pwdata[23:0];
            cpr_pkg::REG_INV_HEIGHT:    inv_height_ff    <= csr_pwdata[23:0];
            cpr_pkg::REG_ASPECT_RATIO:  aspect_ratio_ff  <= csr_pwdata[23:0];
            cpr_pkg::REG_TAN_HALF_FOV:  tan_half_fov_ff  <= csr_pwdata[23:0];
            cpr_pkg::REG_BASIS_RIGHT:   basis_right_ff   <= csr_pwdata[47:0];
            cpr_pkg::REG_BASIS_UP:      basis_up_ff      <= csr_pwdata[47:0];
            cpr_pkg::REG_BASIS_FORWARD: basis_forward_ff <= csr_pwdata[47:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cpr_pkg::csr_index_type'(csr_paddr[5:3]))
         cpr_pkg::REG_INV_WIDTH:     csr_prdata = 64'(inv_width_ff);
         cpr_pkg::REG_INV_HEIGHT:    csr_prdata = 64'(inv_height_ff);
         cpr_pkg::REG_ASPECT_RATIO:  csr_prdata = 64'(aspect_ratio_ff);
         cpr_pkg::REG_TAN_HALF_FOV:  csr_prdata = 64'(tan_half_fov_ff);
         cpr_pkg::REG_BASIS_RIGHT:   csr_prdata = 64'(basis_right_ff);
         cpr_pkg::REG_BASIS_UP:      csr_prdata = 64'(basis_up_ff);
         cpr_pkg::REG_BASIS_FORWARD: csr_prdata = 64'(basis_forward_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   logic            adv;
   logic [NSTG-1:0] vld_ff, vld_in;

   assign adv        = ~vld_ff[NSTG-1] | rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NSTG-1];
   assign vld_in     = {vld_ff[NSTG-2:0], req_tvalid & adv};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   logic [PW-1:0] s1_px_ff, s1_py_ff, s1_px_in, s1_py_in;

   assign s1_px_in = PW'({req_tdata[PIXEL_BITS-1:0], 1'b1}) * PW'(inv_width_ff);
   assign s1_py_in = PW'({req_tdata[2*PIXEL_BITS-1:PIXEL_BITS], 1'b1}) * PW'(inv_height_ff);

   logic [31:0] s2_mu_ff, s2_mv_ff, s2_mu_in, s2_mv_in;
   logic        s2_nu_ff, s2_nv_ff, s2_nu_in, s2_nv_in;
   logic signed [UW-1:0] du, dv;

   always_comb begin
      du = $signed(UW'(s1_px_ff)) - $signed(UW'(cpr_pkg::ONE_Q24));
      dv = $signed(UW'(s1_py_ff)) - $signed(UW'(cpr_pkg::ONE_Q24));
      s2_nu_in = du[UW-1];
      s2_nv_in = dv[UW-1];
      if ((&du[UW-1:31]) || ~(|du[UW-1:31])) begin
         s2_mu_in = s2_nu_in ? ~du[31:0] + 32'd1 : du[31:0];
      end else begin
         s2_mu_in = s2_nu_in ? 32'h8000_0000 : 32'h7fff_ffff;
      end
      if ((&dv[UW-1:31]) || ~(|dv[UW-1:31])) begin
         s2_mv_in = s2_nv_in ? ~dv[31:0] + 32'd1 : dv[31:0];
      end else begin
         s2_mv_in = s2_nv_in ? 32'h8000_0000 : 32'h7fff_ffff;
      end
   end

   logic [55:0] s3_ua_ff, s3_va_ff, s3_ua_in, s3_va_in;
   logic        s3_nu_ff, s3_nv_ff;

   assign s3_ua_in = 56'(s2_mu_ff) * 56'(aspect_ratio_ff);
   assign s3_va_in = 56'(s2_mv_ff) * 56'(tan_half_fov_ff);

   logic [39:0] s4_ua_ff, s4_ua_in;
   logic [31:0] s4_cy_ff, s4_cy_in;
   logic        s4_nu_ff, s4_nv_ff;

   assign s4_ua_in = 40'((s3_ua_ff + 56'h8000) >> 16);
   assign s4_cy_in = 32'((s3_va_ff + 56'h80_0000) >> 24);

   logic [47:0] s5_lo_ff, s5_lo_in;
   logic [39:0] s5_hi_ff, s5_hi_in;
   logic [31:0] s5_cy_ff;
   logic        s5_nu_ff, s5_nv_ff;

   assign s5_lo_in = 48'(s4_ua_ff[23:0]) * 48'(tan_half_fov_ff);
   assign s5_hi_in = 40'(s4_ua_ff[39:24]) * 40'(tan_half_fov_ff);

   logic signed [40:0] s6_cx_ff, s6_cx_in;
   logic signed [32:0] s6_cy_ff, s6_cy_in;
   logic [39:0]        cx_mag;

   always_comb begin
      cx_mag   = s5_hi_ff + 40'((s5_lo_ff + 48'h80_0000) >> 24);
      s6_cx_in = s5_nu_ff ? -$signed({1'b0, cx_mag}) : $signed({1'b0, cx_mag});
      s6_cy_in = s5_nv_ff ? -$signed({1'b0, s5_cy_ff}) : $signed({1'b0, s5_cy_ff});
   end

   logic signed [56:0] s7_pr_ff [3];
   logic signed [56:0] s7_pr_in [3];
   logic signed [48:0] s7_pu_ff [3];
   logic signed [48:0] s7_pu_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s7_pr_in[k] = 57'(s6_cx_ff) * 57'($signed(basis_right_ff[16*k +: 16]));
         s7_pu_in[k] = 49'(s6_cy_ff) * 49'($signed(basis_up_ff[16*k +: 16]));
      end
   end

   logic [55:0]        s8_mag_ff [3];
   logic [55:0]        s8_mag_in [3];
   logic [2:0]         s8_neg_ff, s8_neg_in;
   logic signed [56:0] dsum [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dsum[k] = s7_pr_ff[k] + 57'(s7_pu_ff[k])
                 + 57'($signed({basis_forward_ff[16*k +: 16], 16'h0000}));
         s8_neg_in[k] = dsum[k][56];
         s8_mag_in[k] = s8_neg_in[k] ? 56'(-dsum[k]) : 56'(dsum[k]);
      end
   end

   cpr_pkg::lane_type s9_ff, s9_in;
   logic [55:0]       big;
   logic [4:0]        sh;

   always_comb begin
      big = s8_mag_ff[0] | s8_mag_ff[1] | s8_mag_ff[2];
      sh  = '0;
      for (int i = 30; i < 56; i++) begin
         if (big[i]) begin
            sh = 5'(i - 29);
         end
      end
      s9_in.neg = s8_neg_ff;
      for (int k = 0; k < 3; k++) begin
         s9_in.mag[k] = cpr_pkg::MAG_W'(s8_mag_ff[k] >> sh);
      end
   end

   logic [59:0]       s10_sq_ff [3];
   logic [59:0]       s10_sq_in [3];
   cpr_pkg::lane_type s10_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s10_sq_in[k] = 60'(s9_ff.mag[k]) * 60'(s9_ff.mag[k]);
      end
   end

   logic [cpr_pkg::SUM_W-1:0] sq_x_ff [0:cpr_pkg::ROOT_W];
   logic [cpr_pkg::SUM_W-1:0] sq_r_ff [0:cpr_pkg::ROOT_W];
   cpr_pkg::lane_type         sq_c_ff [0:cpr_pkg::ROOT_W];
   logic [cpr_pkg::SUM_W-1:0] sq_x_in [1:cpr_pkg::ROOT_W];
   logic [cpr_pkg::SUM_W-1:0] sq_r_in [1:cpr_pkg::ROOT_W];
   logic [cpr_pkg::SUM_W-1:0] sum_in;

   assign sum_in = cpr_pkg::SUM_W'(s10_sq_ff[0]) + cpr_pkg::SUM_W'(s10_sq_ff[1])
                 + cpr_pkg::SUM_W'(s10_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_px_ff   <= s1_px_in;
         s1_py_ff   <= s1_py_in;
         s2_mu_ff   <= s2_mu_in;
         s2_mv_ff   <= s2_mv_in;
         s2_nu_ff   <= s2_nu_in;
         s2_nv_ff   <= s2_nv_in;
         s3_ua_ff   <= s3_ua_in;
         s3_va_ff   <= s3_va_in;
         s3_nu_ff   <= s2_nu_ff;
         s3_nv_ff   <= s2_nv_ff;
         s4_ua_ff   <= s4_ua_in;
         s4_cy_ff   <= s4_cy_in;
         s4_nu_ff   <= s3_nu_ff;
         s4_nv_ff   <= s3_nv_ff;
         s5_lo_ff   <= s5_lo_in;
         s5_hi_ff   <= s5_hi_in;
         s5_cy_ff   <= s4_cy_ff;
         s5_nu_ff   <= s4_nu_ff;
         s5_nv_ff   <= s4_nv_ff;
         s6_cx_ff   <= s6_cx_in;
         s6_cy_ff   <= s6_cy_in;
         s7_pr_ff   <= s7_pr_in;
         s7_pu_ff   <= s7_pu_in;
         s8_mag_ff  <= s8_mag_in;
         s8_neg_ff  <= s8_neg_in;
         s9_ff      <= s9_in;
         s10_sq_ff  <= s10_sq_in;
         s10_ff     <= s9_ff;
         sq_x_ff[0] <= sum_in;
         sq_r_ff[0] <= '0;
         sq_c_ff[0] <= s10_ff;
      end
   end

   for (genvar j = 0; j < cpr_pkg::ROOT_W; j++) begin : g_sqrt
      localparam logic [cpr_pkg::SUM_W-1:0] BIT =
         cpr_pkg::SUM_W'(1) << (cpr_pkg::SUM_W - 2 - 2 * j);
      logic [cpr_pkg::SUM_W-1:0] trial;

      always_comb begin
         trial = sq_r_ff[j] + BIT;
         if (sq_x_ff[j] >= trial) begin
            sq_x_in[j+1] = sq_x_ff[j] - trial;
            sq_r_in[j+1] = (sq_r_ff[j] >> 1) + BIT;
         end else begin
            sq_x_in[j+1] = sq_x_ff[j];
            sq_r_in[j+1] = sq_r_ff[j] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_x_ff[j+1] <= sq_x_in[j+1];
            sq_r_ff[j+1] <= sq_r_in[j+1];
            sq_c_ff[j+1] <= sq_c_ff[j];
         end
      end
   end

   cpr_pkg::div_type          dv_ff [0:cpr_pkg::QUO_W];
   cpr_pkg::div_type          dv_in [0:cpr_pkg::QUO_W];
   logic [cpr_pkg::ROOT_W-1:0] root;

   always_comb begin
      root           = sq_r_ff[cpr_pkg::ROOT_W][cpr_pkg::ROOT_W-1:0];
      dv_in[0].neg   = sq_c_ff[cpr_pkg::ROOT_W].neg;
      dv_in[0].zero  = (root == '0);
      dv_in[0].root  = root;
      for (int k = 0; k < 3; k++) begin
         dv_in[0].rem[k] = cpr_pkg::NUM_W'({sq_c_ff[cpr_pkg::ROOT_W].mag[k], 14'h0000})
                         + cpr_pkg::NUM_W'(root >> 1);
         dv_in[0].quo[k] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff[0] <= dv_in[0];
      end
   end

   for (genvar j = 0; j < cpr_pkg::QUO_W; j++) begin : g_div
      localparam int QB = cpr_pkg::QUO_W - 1 - j;
      logic [cpr_pkg::NUM_W-1:0] dsr;

      always_comb begin
         dsr        = cpr_pkg::NUM_W'(dv_ff[j].root) << QB;
         dv_in[j+1] = dv_ff[j];
         for (int k = 0; k < 3; k++) begin
            if (dv_ff[j].rem[k] >= dsr) begin
               dv_in[j+1].rem[k]     = dv_ff[j].rem[k] - dsr;
               dv_in[j+1].quo[k][QB] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[j+1] <= dv_in[j+1];
         end
      end
   end

   logic [2:0][cpr_pkg::DIR_W-1:0] dir_ff, dir_in;
   logic [cpr_pkg::QUO_W-1:0]      qc;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         qc = dv_ff[cpr_pkg::QUO_W].quo[k];
         if (dv_ff[cpr_pkg::QUO_W].zero) begin
            qc = '0;
         end else if (qc > cpr_pkg::UNIT_Q14) begin
            qc = cpr_pkg::UNIT_Q14;
         end
         dir_in[k] = dv_ff[cpr_pkg::QUO_W].neg[k] ? -cpr_pkg::DIR_W'(qc)
                                                  : cpr_pkg::DIR_W'(qc);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dir_ff <= dir_in;
      end
   end

   assign rsp_tdata = dir_ff;

`ifndef SYNTHESIS
   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16'sd16384)
                  && ($signed(rsp_tdata[15:0]) >= -16'sd16384)
                  && ($signed(rsp_tdata[31:16]) <= 16'sd16384)
                  && ($signed(rsp_tdata[31:16]) >= -16'sd16384)
                  && ($signed(rsp_tdata[47:32]) <= 16'sd16384)
                  && ($signed(rsp_tdata[47:32]) >= -16'sd16384))
      else $error("ray direction component out of unit range");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during stall");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire

// File: dv/camera_primary_ray_direction_checker.sv
// Checker for the camera primary ray pipeline: predicts each ray direction and compares results.
module camera_primary_ray_direction_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [23:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic        csr_pready,
   input  wire logic [5:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output int               mismatch_count,
   output int               rays_pending,
   output int               rays_checked
);

   logic [23:0] inv_width, inv_height, aspect_ratio, tan_half_fov;
   logic [47:0] basis_right, basis_up, basis_forward;
   logic [47:0] expected_rays[$];

   function automatic longint round_off(longint val, int sh);
      longint unsigned m;
      m = (val < 0) ? longint'(-val) : val;
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return (val < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clamp_q24(longint val);
      if (val > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (val < -64'sh8000_0000) return -64'sh8000_0000;
      return val;
   endfunction

   function automatic longint basis_half(logic [47:0] packed_vec, int k);
      logic signed [15:0] h;
      h = packed_vec[16*k +: 16];
      return h;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [47:0] ray_direction(logic [11:0] px, logic [11:0] py);
      longint u, v, ua, cx, cy;
      longint dv[3];
      longint unsigned mg[3], big, total, root, q;
      int sh;
      logic [47:0] dir;
      u = clamp_q24((2 * longint'(px) + 1) * longint'(inv_width) - (64'sd1 << 24));
      v = clamp_q24((2 * longint'(py) + 1) * longint'(inv_height) - (64'sd1 << 24));
      ua = round_off(u * longint'(aspect_ratio), 16);
      cx = round_off(ua * longint'(tan_half_fov), 24);
      cy = round_off(v * longint'(tan_half_fov), 24);
      big = 0;
      for (int k = 0; k < 3; k++) begin
         dv[k] = cx * basis_half(basis_right, k) + cy * basis_half(basis_up, k)
               + basis_half(basis_forward, k) * 65536;
         mg[k] = (dv[k] < 0) ? longint'(-dv[k]) : dv[k];
         if (mg[k] > big) big = mg[k];
      end
      sh = 0;
      while ((big >> sh) >= (64'd1 << 30)) sh++;
      total = 0;
      for (int k = 0; k < 3; k++) begin
         mg[k] >>= sh;
         total += mg[k] * mg[k];
      end
      root = floor_sqrt(total);
      for (int k = 0; k < 3; k++) begin
         q = 0;
         if (root != 0) begin
            q = (mg[k] * 16384 + root / 2) / root;
            if (q > 16384) q = 16384;
         end
         dir[16*k +: 16] = (dv[k] < 0) ? 16'(-q) : 16'(q);
      end
      return dir;
   endfunction

   always @(posedge clock) begin
      logic [47:0] want;
      if (reset) begin
         inv_width      <= cpr_pkg::INV_WIDTH_RST;
         inv_height     <= cpr_pkg::INV_HEIGHT_RST;
         aspect_ratio   <= cpr_pkg::ASPECT_RST;
         tan_half_fov   <= cpr_pkg::TAN_HALF_FOV_RST;
         basis_right    <= cpr_pkg::RIGHT_RST;
         basis_up       <= cpr_pkg::UP_RST;
         basis_forward  <= cpr_pkg::FORWARD_RST;
         expected_rays.delete();
         mismatch_count <= 0;
         rays_checked   <= 0;
         rays_pending   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rays.push_back(ray_direction(req_tdata[11:0], req_tdata[23:12]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rays.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected ray result %h", rsp_tdata);
            end else begin
               want = expected_rays.pop_front();
               rays_checked <= rays_checked + 1;
               for (int k = 0; k < 3; k++) begin
                  if (want[16*k +: 16] !== rsp_tdata[16*k +: 16]) begin
                     mismatch_count <= mismatch_count + 1;
                     if (mismatch_count < 10)
                        $display("ray %0d dir component %0d: expected %0d, got %0d",
                                 rays_checked, k, $signed(want[16*k +: 16]),
                                 $signed(rsp_tdata[16*k +: 16]));
                     break;
                  end
               end
            end
         end
         rays_pending <= expected_rays.size();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[5:3])
               cpr_pkg::REG_INV_WIDTH:     inv_width     <= csr_pwdata[23:0];
               cpr_pkg::REG_INV_HEIGHT:    inv_height    <= csr_pwdata[23:0];
               cpr_pkg::REG_ASPECT_RATIO:  aspect_ratio  <= csr_pwdata[23:0];
               cpr_pkg::REG_TAN_HALF_FOV:  tan_half_fov  <= csr_pwdata[23:0];
               cpr_pkg::REG_BASIS_RIGHT:   basis_right   <= csr_pwdata[47:0];
               cpr_pkg::REG_BASIS_UP:      basis_up      <= csr_pwdata[47:0];
               cpr_pkg::REG_BASIS_FORWARD: basis_forward <= csr_pwdata[47:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// File: dv/camera_primary_ray_direction_tb.sv
// Testbench top for the camera primary ray pipeline: stimulus, register setup and verdict.
module camera_primary_ray_direction_tb;

   localparam int UNUSED_REG = 7;
   localparam int DRAIN_CYCLES = 70;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = 0;     // pixel_x, pixel_y
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;         // dir_x, dir_y, dir_z
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [5:0]  csr_paddr = 0;
   logic [63:0] csr_pwdata = 0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   int  mismatch_count, rays_pending, rays_checked;
   int  settings_used = 1;
   bit  steady = 0;
   bit  stall_request = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   camera_primary_ray_direction uut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   camera_primary_ray_direction_checker checker_i (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .mismatch_count, .rays_pending, .rays_checked
   );

   // hold off the receiver when asked, otherwise stall at random unless steady
   always @(posedge clock) begin
      if (stall_request) begin
         rsp_tready <= 0;
         repeat (400) @(posedge clock);
         stall_request = 0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 33);
      end
   end

   task automatic send_pixel(logic [11:0] px, logic [11:0] py);
      if (!steady && $urandom_range(99) < 33) begin
         req_tvalid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < 33) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {py, px};
      forever begin
         @(negedge clock);
         if (req_tready) break;
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      @(posedge clock);
      while (rays_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(int index, logic [63:0] value);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= 6'(index * 8);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      forever begin
         @(negedge clock);
         if (csr_pready) break;
         @(posedge clock);
      end
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
   endtask

   function automatic logic [63:0] random_wide();
      return {$urandom(), $urandom()};
   endfunction

   task automatic set_camera(logic [23:0] iw, logic [23:0] ih, logic [23:0] ar,
                             logic [23:0] tf, logic [63:0] rt, logic [63:0] up,
                             logic [63:0] fw);
      wait_idle();
      write_reg(cpr_pkg::REG_INV_WIDTH, {$urandom(), 8'h00, iw});
      write_reg(cpr_pkg::REG_INV_HEIGHT, {32'h0, 8'hFF, ih});
      write_reg(cpr_pkg::REG_ASPECT_RATIO, {32'h0, 8'h00, ar});
      write_reg(cpr_pkg::REG_TAN_HALF_FOV, {32'h0, 8'h00, tf});
      write_reg(cpr_pkg::REG_BASIS_RIGHT, rt);
      write_reg(cpr_pkg::REG_BASIS_UP, up);
      write_reg(cpr_pkg::REG_BASIS_FORWARD, fw);
      write_reg(UNUSED_REG, random_wide());
      settings_used++;
   endtask

   initial begin
      logic [11:0] px, py;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // corners, pixel center edges and bit patterns at the default camera
      send_pixel(0, 0);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(0, 12'hFFF);
      send_pixel(12'hFFF, 0);
      send_pixel(31, 31);
      send_pixel(32, 32);
      send_pixel(63, 0);
      send_pixel(12'hAAA, 12'h555);
      send_pixel(12'h555, 12'hAAA);
      send_pixel(12'h800, 12'h7FF);
      // saturated scale and degenerate direction
      set_camera(24'hFFFFFF, 24'hFFFFFF, 24'h010000, 24'h010000, 0, 0, 0);
      send_pixel(0, 0);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'h800, 12'h001);
      set_camera(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                 64'hFFFF_8000_8000_8000, 64'h0000_7FFF_7FFF_7FFF,
                 64'h1234_8000_7FFF_8000);
      send_pixel(0, 0);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'hFFF, 0);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_camera(24'd26214, 24'd34953, 24'd87381, 24'd37837,
                          48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000);
            1: set_camera(0, 0, 0, 0, random_wide(), random_wide(), random_wide());
            2: set_camera(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                          random_wide(), random_wide(), random_wide());
            3: set_camera(0, 0, 0, 0, 0, 0, 0);
            default: set_camera(24'($urandom()), 24'($urandom()), 24'($urandom()),
                                24'($urandom()), random_wide(), random_wide(),
                                random_wide());
         endcase
         if (phase == 4) stall_request = 1;
         steady = (phase == 5);
         for (int i = 0; i < 100; i++) begin
            if ($urandom_range(1)) begin
               px = 12'($urandom_range(639));
               py = 12'($urandom_range(479));
            end else begin
               px = 12'($urandom());
               py = 12'($urandom());
            end
            send_pixel(px, py);
         end
         steady = 0;
      end
      wait_idle();

      $display("checked %0d ray directions across %0d camera register settings",
               rays_checked, settings_used);
      if (mismatch_count == 0)
         $display("camera_primary_ray_direction test passed");
      else
         $display("camera_primary_ray_direction test failed");
      $finish;
   end

   initial begin
      #1000000;
      $display("camera_primary_ray_direction test failed");
      $finish;
   end

endmodule
